### rtl/psm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// psm_pkg
// Shared types, codes and default sizes of the p-code stack machine core.
// ============================================================================
package psm_pkg;

    localparam int OPCODE_W  = 3;
    localparam int LEVEL_W   = 2;
    localparam int OPERAND_W = 11;
    localparam int PC_OUT_W  = 11;
    localparam int DATA_W    = 32;
    localparam int TOP_OUT_W = 13;
    localparam int ERR_W     = 2;

    // CODE_DEPTH and STACK_DEPTH are powers of two.
    localparam int STACK_DEPTH_DEF = 4096;
    localparam int MAX_LEVEL_DEF   = 3;
    localparam int CODE_DEPTH_DEF  = 2048;

    localparam logic [OPCODE_W-1:0] OP_LIT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_OPR = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_LOD = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_STO = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CAL = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_INT = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_JMP = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_JPC = 3'd7;

    localparam logic [OPERAND_W-1:0] OPR_RET = 11'd0;
    localparam logic [OPERAND_W-1:0] OPR_NEG = 11'd1;
    localparam logic [OPERAND_W-1:0] OPR_ADD = 11'd2;
    localparam logic [OPERAND_W-1:0] OPR_SUB = 11'd3;
    localparam logic [OPERAND_W-1:0] OPR_MUL = 11'd4;
    localparam logic [OPERAND_W-1:0] OPR_DIV = 11'd5;
    localparam logic [OPERAND_W-1:0] OPR_ODD = 11'd6;
    localparam logic [OPERAND_W-1:0] OPR_EQ  = 11'd8;
    localparam logic [OPERAND_W-1:0] OPR_NE  = 11'd9;
    localparam logic [OPERAND_W-1:0] OPR_LT  = 11'd10;
    localparam logic [OPERAND_W-1:0] OPR_GE  = 11'd11;
    localparam logic [OPERAND_W-1:0] OPR_GT  = 11'd12;
    localparam logic [OPERAND_W-1:0] OPR_LE  = 11'd13;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_STACK = 2'd2;

endpackage

### rtl/psm_if.sv
`timescale 1ns / 1ps
// ============================================================================
// psm_instr_if / psm_result_if
// Valid/ready channels for instructions and step results.
// ============================================================================
interface psm_instr_if import psm_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [LEVEL_W-1:0]   level;
    logic [OPERAND_W-1:0] operand;

    modport source (output valid, output opcode, output level, output operand, input ready);
    modport sink   (input valid, input opcode, input level, input operand, output ready);
endinterface

interface psm_result_if import psm_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [PC_OUT_W-1:0]         next_pc;
    logic signed [DATA_W-1:0]    top_value;
    logic signed [TOP_OUT_W-1:0] stack_top;
    logic                        halted;
    logic [ERR_W-1:0]            error_code;

    modport source (output valid, output next_pc, output top_value, output stack_top,
                    output halted, output error_code, input ready);
    modport sink   (input valid, input next_pc, input top_value, input stack_top,
                    input halted, input error_code, output ready);
endinterface

### rtl/pcode_stack_machine_core.sv
`timescale 1ns / 1ps
// ============================================================================
// pcode_stack_machine_core
// PL/0 p-code executor holding the data stack in one synchronous memory.
// ----------------------------------------------------------------------------
// Each transaction on i_instr carries one instruction (opcode, level, operand)
// that an external fetcher read from the address last reported as next_pc.
// Each instruction yields exactly one transaction on o_result with the next
// program address, the top of stack, the stack index, the halt flag and an
// error code. One instruction is in flight at a time.
// The time an instruction takes from acceptance to result depends on the
// operation and is shortest once halted; each static link hop, the frame
// writes of a call and a divide add to it. The single-port stack memory,
// the link walk and the bit-serial divider set this timing.
// After reset the block sweeps all STACK_DEPTH stack memory entries to zero,
// one entry per cycle, and holds i_instr.ready low meanwhile.
// A result waits in the output register while o_result.ready is low; a new
// instruction is accepted when that register is free or being emptied.
// Once halted, instructions change nothing and repeat the final state.
// ============================================================================
module pcode_stack_machine_core import psm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
    parameter int CODE_DEPTH  = CODE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psm_instr_if.sink    i_instr,
    psm_result_if.source o_result
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = AW + 1;
    localparam int PW = $clog2(CODE_DEPTH);
    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam int EW = ((AW > OPERAND_W) ? AW : OPERAND_W) + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_LINK, S_LWAIT, S_RA, S_RB,
        S_EXE, S_DIV, S_CAL, S_FIN, S_FWAIT
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic signed [TW-1:0]    r_top, n_top;
    logic [AW-1:0]           r_base, n_base;
    logic [PW-1:0]           r_pc, n_pc;
    logic                    r_stop, n_stop;
    logic [OPCODE_W-1:0]     r_op, n_op;
    logic [LW-1:0]           r_lev, n_lev;
    logic [OPERAND_W-1:0]    r_a, n_a;
    logic [ERR_W-1:0]        r_err, n_err;
    logic [AW-1:0]           r_link, n_link;
    logic [DATA_W-1:0]       r_x, n_x;
    logic [DATA_W-1:0]       r_y, n_y;
    logic [1:0]              r_cal, n_cal;
    logic                    r_ovalid, n_ovalid;
    logic [PC_OUT_W-1:0]     r_o_pc, n_o_pc;
    logic [DATA_W-1:0]       r_o_val, n_o_val;
    logic [TOP_OUT_W-1:0]    r_o_top, n_o_top;
    logic                    r_o_halt, n_o_halt;
    logic [ERR_W-1:0]        r_o_err, n_o_err;

    logic [DATA_W-1:0]       mem [STACK_DEPTH];
    logic [DATA_W-1:0]       r_rdata;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [DATA_W-1:0]       mem_wdata;

    logic                    div_start, div_done;
    logic [DATA_W-1:0]       div_q;

    logic                    in_accept;
    logic signed [EW-1:0]    t_e, d_e, a_e;
    logic [EW-1:0]           fa;
    logic                    full1, full3, empty, lt2, int_bad, addr_bad, base_bad, link_bad;
    logic signed [TW-1:0]    tp1, tm1;
    logic [PW-1:0]           a_pc, pc_inc;
    logic [DATA_W-1:0]       a32;
    logic                    is_un, is_bin;
    logic [DATA_W-1:0]       alu;
    logic signed [DATA_W-1:0] top32;
    logic [DATA_W-1:0]       pc32;

    assign t_e      = EW'(r_top);
    assign d_e      = EW'(STACK_DEPTH);
    assign a_e      = $signed(EW'(r_a));
    assign full1    = (t_e + EW'(1)) >= d_e;
    assign full3    = (t_e + EW'(3)) >= d_e;
    assign empty    = r_top < 0;
    assign lt2      = r_top < TW'(1);
    assign int_bad  = (t_e + a_e) >= d_e;
    assign fa       = EW'(r_link) + EW'(r_a);
    assign addr_bad = fa >= EW'(STACK_DEPTH);
    assign base_bad = (EW'(r_base) + EW'(2)) >= EW'(STACK_DEPTH);
    assign link_bad = r_rdata >= DATA_W'(STACK_DEPTH);
    assign tp1      = r_top + TW'(1);
    assign tm1      = r_top - TW'(1);
    assign a32      = DATA_W'(r_a);
    assign a_pc     = a32[PW-1:0];
    assign pc_inc   = (r_pc == PW'(CODE_DEPTH - 1)) ? '0 : r_pc + PW'(1);
    assign is_un    = (r_a == OPR_NEG) || (r_a == OPR_ODD);
    assign is_bin   = r_a inside {[OPR_ADD:OPR_DIV], [OPR_EQ:OPR_LE]};
    assign top32    = DATA_W'(r_top);
    assign pc32     = DATA_W'(r_pc);

    assign in_accept     = i_instr.valid && i_instr.ready;
    assign i_instr.ready = (r_state == S_IDLE) && (!r_ovalid || o_result.ready);

    always_comb begin
        case (r_a)
            OPR_ADD: alu = r_x + r_y;
            OPR_SUB: alu = r_x - r_y;
            OPR_MUL: alu = r_x * r_y;
            OPR_EQ:  alu = DATA_W'(r_x == r_y);
            OPR_NE:  alu = DATA_W'(r_x != r_y);
            OPR_LT:  alu = DATA_W'($signed(r_x) < $signed(r_y));
            OPR_GE:  alu = DATA_W'($signed(r_x) >= $signed(r_y));
            OPR_GT:  alu = DATA_W'($signed(r_x) > $signed(r_y));
            OPR_LE:  alu = DATA_W'($signed(r_x) <= $signed(r_y));
            default: alu = '0;
        endcase
    end

    psm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_top     = r_top;
        n_base    = r_base;
        n_pc      = r_pc;
        n_stop    = r_stop;
        n_op      = r_op;
        n_lev     = r_lev;
        n_a       = r_a;
        n_err     = r_err;
        n_link    = r_link;
        n_x       = r_x;
        n_y       = r_y;
        n_cal     = r_cal;
        n_ovalid  = r_ovalid && !o_result.ready;
        n_o_pc    = r_o_pc;
        n_o_val   = r_o_val;
        n_o_top   = r_o_top;
        n_o_halt  = r_o_halt;
        n_o_err   = r_o_err;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        mem_wdata = '0;
        div_start = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(STACK_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_op  = i_instr.opcode;
                    n_a   = i_instr.operand;
                    n_lev = (i_instr.level > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(i_instr.level);
                    n_err = ERR_NONE;
                    if (r_stop) begin
                        n_state = S_FIN;
                    end else begin
                        n_pc    = pc_inc;
                        n_state = S_DEC;
                    end
                end
            end
            S_DEC: begin
                n_link  = r_base;
                n_state = S_FIN;
                case (r_op)
                    OP_LIT: begin
                        if (full1) begin
                            n_err = ERR_STACK;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = tp1[AW-1:0];
                            mem_wdata = a32;
                            n_top     = tp1;
                        end
                    end
                    OP_OPR: begin
                        if (r_a == OPR_RET) begin
                            if (base_bad) begin
                                n_err = ERR_STACK;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_base + AW'(1);
                                n_state   = S_RA;
                            end
                        end else if (is_un) begin
                            if (empty) begin
                                n_err = ERR_STACK;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_top[AW-1:0];
                                n_state   = S_RA;
                            end
                        end else if (is_bin) begin
                            if (lt2) begin
                                n_err = ERR_STACK;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = tm1[AW-1:0];
                                n_state   = S_RA;
                            end
                        end
                    end
                    OP_LOD: begin
                        if (full1) n_err = ERR_STACK;
                        else n_state = S_LINK;
                    end
                    OP_STO: begin
                        if (empty) n_err = ERR_STACK;
                        else n_state = S_LINK;
                    end
                    OP_CAL: begin
                        if (full3) n_err = ERR_STACK;
                        else n_state = S_LINK;
                    end
                    OP_INT: begin
                        if (int_bad) n_err = ERR_STACK;
                        else n_top = TW'(t_e + a_e);
                    end
                    OP_JMP: begin
                        n_pc = a_pc;
                    end
                    OP_JPC: begin
                        if (empty) begin
                            n_err = ERR_STACK;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_top[AW-1:0];
                            n_state   = S_RA;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_LINK: begin
                if (r_lev != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_link;
                    n_state   = S_LWAIT;
                end else if (r_op == OP_CAL) begin
                    n_cal   = '0;
                    n_state = S_CAL;
                end else if (addr_bad) begin
                    n_err   = ERR_STACK;
                    n_state = S_FIN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = (r_op == OP_LOD) ? fa[AW-1:0] : r_top[AW-1:0];
                    n_state   = S_RA;
                end
            end
            S_LWAIT: begin
                if (link_bad) begin
                    n_err   = ERR_STACK;
                    n_state = S_FIN;
                end else begin
                    n_link  = r_rdata[AW-1:0];
                    n_lev   = r_lev - LW'(1);
                    n_state = S_LINK;
                end
            end
            S_RA: begin
                n_state = S_FIN;
                case (r_op)
                    OP_OPR: begin
                        if (r_a == OPR_RET) begin
                            n_x       = r_rdata;
                            mem_re    = 1'b1;
                            mem_raddr = r_base + AW'(2);
                            n_state   = S_RB;
                        end else if (is_un) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_top[AW-1:0];
                            mem_wdata = (r_a == OPR_NEG) ? (DATA_W'(0) - r_rdata)
                                                         : DATA_W'(r_rdata[0]);
                        end else begin
                            n_x       = r_rdata;
                            mem_re    = 1'b1;
                            mem_raddr = r_top[AW-1:0];
                            n_state   = S_RB;
                        end
                    end
                    OP_LOD: begin
                        mem_we    = 1'b1;
                        mem_waddr = tp1[AW-1:0];
                        mem_wdata = r_rdata;
                        n_top     = tp1;
                    end
                    OP_STO: begin
                        mem_we    = 1'b1;
                        mem_waddr = fa[AW-1:0];
                        mem_wdata = r_rdata;
                        n_top     = tm1;
                    end
                    OP_JPC: begin
                        if (r_rdata == '0) n_pc = a_pc;
                        n_top = tm1;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_RB: begin
                if (r_a == OPR_RET) begin
                    n_state = S_FIN;
                    if (r_x >= DATA_W'(STACK_DEPTH)) begin
                        n_err = ERR_STACK;
                    end else begin
                        n_top  = $signed({1'b0, r_base}) - TW'(1);
                        n_pc   = r_rdata[PW-1:0];
                        n_base = r_x[AW-1:0];
                    end
                end else begin
                    n_y     = r_rdata;
                    n_state = S_EXE;
                end
            end
            S_EXE: begin
                if (r_a != OPR_DIV) begin
                    mem_we    = 1'b1;
                    mem_waddr = tm1[AW-1:0];
                    mem_wdata = alu;
                    n_top     = tm1;
                    n_state   = S_FIN;
                end else if (r_y == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = tm1[AW-1:0];
                    n_err     = ERR_DIV0;
                    n_top     = tm1;
                    n_state   = S_FIN;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    mem_we    = 1'b1;
                    mem_waddr = tm1[AW-1:0];
                    mem_wdata = div_q;
                    n_top     = tm1;
                    n_state   = S_FIN;
                end
            end
            S_CAL: begin
                mem_we    = 1'b1;
                mem_waddr = tp1[AW-1:0] + AW'(r_cal);
                case (r_cal)
                    2'd0:    mem_wdata = DATA_W'(r_link);
                    2'd1:    mem_wdata = DATA_W'(r_base);
                    default: mem_wdata = pc32;
                endcase
                n_cal = r_cal + 2'd1;
                if (r_cal == 2'd2) begin
                    n_base  = tp1[AW-1:0];
                    n_pc    = a_pc;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_pc == '0) n_stop = 1'b1;
                mem_re    = !empty;
                mem_raddr = r_top[AW-1:0];
                n_state   = S_FWAIT;
            end
            S_FWAIT: begin
                n_ovalid = 1'b1;
                n_o_pc   = pc32[PC_OUT_W-1:0];
                n_o_val  = empty ? '0 : r_rdata;
                n_o_top  = top32[TOP_OUT_W-1:0];
                n_o_halt = r_stop;
                n_o_err  = r_err;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_top    <= '1;
            r_base   <= '0;
            r_pc     <= '0;
            r_stop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_top    <= n_top;
            r_base   <= n_base;
            r_pc     <= n_pc;
            r_stop   <= n_stop;
            r_ovalid <= n_ovalid;
        end
        r_op     <= n_op;
        r_lev    <= n_lev;
        r_a      <= n_a;
        r_err    <= n_err;
        r_link   <= n_link;
        r_x      <= n_x;
        r_y      <= n_y;
        r_cal    <= n_cal;
        r_o_pc   <= n_o_pc;
        r_o_val  <= n_o_val;
        r_o_top  <= n_o_top;
        r_o_halt <= n_o_halt;
        r_o_err  <= n_o_err;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    assign o_result.valid      = r_ovalid;
    assign o_result.next_pc    = r_o_pc;
    assign o_result.top_value  = r_o_val;
    assign o_result.stack_top  = r_o_top;
    assign o_result.halted     = r_o_halt;
    assign o_result.error_code = r_o_err;
endmodule

### rtl/psm_div.sv
`timescale 1ns / 1ps
// ============================================================================
// psm_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ============================================================================
module psm_div import psm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);
    localparam int CW = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_mag_b;
    logic              r_neg;
    logic [DATA_W:0]   rem_sh;
    logic              q_bit;
    logic [DATA_W:0]   rem_sub;

    assign rem_sh  = {r_rem, r_dvd[DATA_W-1]};
    assign q_bit   = rem_sh >= {1'b0, r_mag_b};
    assign rem_sub = rem_sh - {1'b0, r_mag_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CW'(DATA_W - 1);
                r_rem   <= '0;
                r_dvd   <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
                r_mag_b <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
                r_neg   <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            end else if (r_busy) begin
                r_rem <= q_bit ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                r_dvd <= {r_dvd[DATA_W-2:0], q_bit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (DATA_W'(0) - r_dvd) : r_dvd;
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench of the p-code stack machine core.
// ----------------------------------------------------------------------------
// Instructions pass through a queue that a clocked driver empties, and a
// clocked monitor compares every result field with a local model of the
// machine. Directed programs cover the operators, the faults and the calls.
// Random programs follow. The run ends with a jump to address zero, which
// halts the machine, and a few instructions after the halt.
// ============================================================================
module tb;
    import psm_pkg::*;

    localparam int STK = STACK_DEPTH_DEF;
    localparam int CODE = CODE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS = 650;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [LEVEL_W-1:0]   level;
        logic [OPERAND_W-1:0] operand;
    } t_instr;

    typedef struct packed {
        logic [PC_OUT_W-1:0]         next_pc;
        logic signed [DATA_W-1:0]    top_value;
        logic signed [TOP_OUT_W-1:0] stack_top;
        logic                        halted;
        logic [ERR_W-1:0]            error_code;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    psm_instr_if  instr_if ();
    psm_result_if result_if ();

    pcode_stack_machine_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_if.sink),
        .o_result (result_if.source)
    );

    t_instr instr_q[$];
    t_step  step_q[$];

    logic [DATA_W-1:0] mem[STK];
    int                tix;
    logic [31:0]       base;
    logic [10:0]       pc;
    bit                stopped;

    int  fail_cnt;
    int  cycle_cnt;
    int  sent_cnt;
    bit  in_fire;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic bit walk_links(input logic [1:0] lev, output logic [31:0] found);
        logic [31:0] b;
        int          n;
        b = base;
        n = int'(lev);
        if (n > MAX_LEVEL_DEF) n = MAX_LEVEL_DEF;
        while (n > 0) begin
            if (b >= STK) return 1'b0;
            b = mem[b];
            n--;
        end
        if (b >= STK) return 1'b0;
        found = b;
        return 1'b1;
    endfunction

    function automatic bit lt_signed(input logic [31:0] x, input logic [31:0] y);
        return $signed(x) < $signed(y);
    endfunction

    function automatic logic [31:0] quotient(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] q;
        mx = x[31] ? 32'd0 - x : x;
        my = y[31] ? 32'd0 - y : y;
        q = mx / my;
        if (x[31] ^ y[31]) q = 32'd0 - q;
        return q;
    endfunction

    // Program counter that an instruction would leave, without changing state.
    function automatic logic [10:0] pc_after(input t_instr ins);
        logic [31:0] fb;
        logic [10:0] npc;
        npc = pc + 11'd1;
        case (ins.opcode)
            OP_JMP: npc = ins.operand;
            OP_JPC: if (tix >= 0 && mem[tix] == 32'd0) npc = ins.operand;
            OP_CAL: if (tix + 3 < STK && walk_links(ins.level, fb)) npc = ins.operand;
            OP_OPR: begin
                if (ins.operand == OPR_RET && base + 2 < STK && mem[base + 1] < STK)
                    npc = 11'(mem[base + 2] % CODE);
            end
            default: ;
        endcase
        return npc;
    endfunction

    task automatic execute(input t_instr ins, output t_step res);
        logic [1:0]  err;
        int          t;
        int          a;
        logic [31:0] fb;
        logic [31:0] addr;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] r;
        logic [31:0] nb;
        err = ERR_NONE;
        t = tix;
        a = int'(ins.operand);
        if (!stopped) begin
            pc = pc + 11'd1;
            case (ins.opcode)
                OP_LIT: begin
                    if (t + 1 >= STK) err = ERR_STACK;
                    else begin
                        tix = t + 1;
                        mem[tix] = a;
                    end
                end
                OP_OPR: begin
                    if (ins.operand == OPR_RET) begin
                        if (base + 2 >= STK || mem[base + 1] >= STK) err = ERR_STACK;
                        else begin
                            nb = mem[base + 1];
                            tix = int'(base) - 1;
                            pc = 11'(mem[base + 2] % CODE);
                            base = nb;
                        end
                    end else if (ins.operand == OPR_NEG || ins.operand == OPR_ODD) begin
                        if (t < 0) err = ERR_STACK;
                        else begin
                            x = mem[t];
                            mem[t] = (ins.operand == OPR_NEG) ? 32'd0 - x : {31'd0, x[0]};
                        end
                    end else if ((a >= OPR_ADD && a <= OPR_DIV) ||
                                 (a >= OPR_EQ && a <= OPR_LE)) begin
                        if (t < 1) err = ERR_STACK;
                        else begin
                            x = mem[t - 1];
                            y = mem[t];
                            case (ins.operand)
                                OPR_ADD: r = x + y;
                                OPR_SUB: r = x - y;
                                OPR_MUL: r = x * y;
                                OPR_DIV: begin
                                    if (y == 32'd0) begin
                                        r = 32'd0;
                                        err = ERR_DIV0;
                                    end else begin
                                        r = quotient(x, y);
                                    end
                                end
                                OPR_EQ:  r = 32'(x == y);
                                OPR_NE:  r = 32'(x != y);
                                OPR_LT:  r = 32'(lt_signed(x, y));
                                OPR_GE:  r = 32'(!lt_signed(x, y));
                                OPR_GT:  r = 32'(lt_signed(y, x));
                                default: r = 32'(!lt_signed(y, x));
                            endcase
                            tix = t - 1;
                            mem[tix] = r;
                        end
                    end
                end
                OP_LOD: begin
                    if (t + 1 >= STK || !walk_links(ins.level, fb)) err = ERR_STACK;
                    else begin
                        addr = fb + a;
                        if (addr >= STK) err = ERR_STACK;
                        else begin
                            tix = t + 1;
                            mem[tix] = mem[addr];
                        end
                    end
                end
                OP_STO: begin
                    if (t < 0 || !walk_links(ins.level, fb)) err = ERR_STACK;
                    else begin
                        addr = fb + a;
                        if (addr >= STK) err = ERR_STACK;
                        else begin
                            mem[addr] = mem[t];
                            tix = t - 1;
                        end
                    end
                end
                OP_CAL: begin
                    if (t + 3 >= STK || !walk_links(ins.level, fb)) err = ERR_STACK;
                    else begin
                        mem[t + 1] = fb;
                        mem[t + 2] = base;
                        mem[t + 3] = 32'(pc);
                        base = 32'(t + 1);
                        pc = ins.operand;
                    end
                end
                OP_INT: begin
                    if (t + a >= STK) err = ERR_STACK;
                    else tix = t + a;
                end
                OP_JMP: pc = ins.operand;
                default: begin
                    if (t < 0) err = ERR_STACK;
                    else begin
                        if (mem[t] == 32'd0) pc = ins.operand;
                        tix = t - 1;
                    end
                end
            endcase
            if (pc == 11'd0) stopped = 1'b1;
        end
        res.next_pc    = pc;
        res.top_value  = (tix >= 0) ? mem[tix] : 32'd0;
        res.stack_top  = tix[TOP_OUT_W-1:0];
        res.halted     = stopped;
        res.error_code = err;
    endtask

    task automatic issue(input logic [2:0] op, input int lev, input int a);
        t_instr ins;
        t_step  res;
        ins.opcode  = op;
        ins.level   = lev[LEVEL_W-1:0];
        ins.operand = a[OPERAND_W-1:0];
        execute(ins, res);
        instr_q.push_back(ins);
        step_q.push_back(res);
    endtask

    function automatic t_instr random_instr();
        t_instr ins;
        int     pick;
        ins.level   = 2'($urandom_range(3));
        ins.operand = 11'($urandom);
        pick = int'($urandom_range(99));
        if (tix > 3000 && pick < 40) pick = 30;
        if (pick < 25) begin
            ins.opcode = OP_LIT;
        end else if (pick < 50) begin
            ins.opcode = OP_OPR;
            ins.operand = 11'($urandom_range(13));
            if (ins.operand == OPR_RET && $urandom_range(3) != 0) ins.operand = OPR_ADD;
        end else if (pick < 62) begin
            ins.opcode = OP_LOD;
            ins.operand = 11'($urandom_range(7));
        end else if (pick < 72) begin
            ins.opcode = OP_STO;
            ins.operand = 11'($urandom_range(7));
        end else if (pick < 78) begin
            ins.opcode = OP_CAL;
        end else if (pick < 84) begin
            ins.opcode = OP_INT;
            ins.operand = 11'($urandom_range(6));
        end else if (pick < 88) begin
            ins.opcode = OP_JMP;
        end else if (pick < 94) begin
            ins.opcode = OP_JPC;
        end else begin
            ins.opcode = 3'($urandom_range(7));
        end
        return ins;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_cnt, field, got, want);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        in_fire <= instr_if.valid && instr_if.ready;
    end

    always @(negedge i_clk) begin
        t_instr ins;
        if (!instr_if.valid || in_fire) begin
            if (instr_q.size() > 0 &&
                ((sent_cnt >= 250 && sent_cnt < 400) || $urandom_range(99) >= 8)) begin
                ins = instr_q.pop_front();
                instr_if.valid   <= 1'b1;
                instr_if.opcode  <= ins.opcode;
                instr_if.level   <= ins.level;
                instr_if.operand <= ins.operand;
                sent_cnt <= sent_cnt + 1;
            end else begin
                instr_if.valid <= 1'b0;
            end
        end
        result_if.ready <= (sent_cnt >= 250 && sent_cnt < 400) || $urandom_range(99) >= 8;
    end

    always @(posedge i_clk) begin
        t_step want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (step_q.size() == 0) begin
                report("unexpected transaction", 32'd0, 32'd0);
            end else begin
                want = step_q.pop_front();
                if (result_if.next_pc !== want.next_pc)
                    report("next_pc", 32'(result_if.next_pc), 32'(want.next_pc));
                if (result_if.top_value !== want.top_value)
                    report("top_value", result_if.top_value, want.top_value);
                if (result_if.stack_top !== want.stack_top)
                    report("stack_top", 32'(result_if.stack_top), 32'(want.stack_top));
                if (result_if.halted !== want.halted)
                    report("halted", 32'(result_if.halted), 32'(want.halted));
                if (result_if.error_code !== want.error_code)
                    report("error_code", 32'(result_if.error_code), 32'(want.error_code));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_instr ins;
        int     n;
        instr_if.valid   = 1'b0;
        instr_if.opcode  = OP_LIT;
        instr_if.level   = 2'd0;
        instr_if.operand = 11'd0;
        result_if.ready  = 1'b0;
        in_fire   = 1'b0;
        fail_cnt  = 0;
        cycle_cnt = 0;
        sent_cnt  = 0;
        for (int k = 0; k < STK; k++) mem[k] = 32'd0;
        tix = -1;
        base = 32'd0;
        pc = 11'd0;
        stopped = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Faults on an empty stack, then arithmetic and the divide cases.
        issue(OP_OPR, 0, OPR_ADD);
        issue(OP_JPC, 0, 300);
        issue(OP_LIT, 0, 2047);
        issue(OP_OPR, 0, OPR_NEG);
        issue(OP_OPR, 0, OPR_ODD);
        issue(OP_LIT, 0, 0);
        issue(OP_OPR, 0, OPR_DIV);
        issue(OP_LIT, 0, 1024);
        issue(OP_LIT, 0, 1024);
        issue(OP_OPR, 0, OPR_MUL);
        issue(OP_LIT, 0, 2048 - 1);
        issue(OP_OPR, 0, OPR_SUB);
        issue(OP_LIT, 0, 1024);
        issue(OP_OPR, 0, OPR_MUL);
        issue(OP_LIT, 0, 1);
        issue(OP_OPR, 0, OPR_NEG);
        issue(OP_OPR, 0, OPR_DIV);
        for (int k = OPR_EQ; k <= OPR_LE; k++) begin
            issue(OP_LIT, 0, 5);
            issue(OP_LIT, 0, k);
            issue(OP_OPR, 0, k);
        end
        issue(OP_OPR, 0, 7);
        issue(OP_OPR, 0, 2047);
        issue(OP_LOD, 3, 2047);
        issue(OP_STO, 3, 1);
        issue(OP_CAL, 3, 900);
        issue(OP_INT, 0, 2);
        issue(OP_OPR, 0, OPR_RET);
        // The conditional jump sits at the last address, so the counter wraps
        // to zero before the jump is taken and the machine keeps running.
        issue(OP_JMP, 0, 2046);
        issue(OP_LIT, 0, 0);
        issue(OP_JPC, 0, 40);
        issue(OP_INT, 0, 2047);
        issue(OP_INT, 0, 2047);
        issue(OP_LIT, 0, 9);
        issue(OP_LIT, 0, 9);
        issue(OP_LIT, 0, 9);
        issue(OP_CAL, 0, 55);
        // Return to a frame base of zero through a stored return address.
        issue(OP_LIT, 0, 60);
        issue(OP_STO, 0, 2);
        issue(OP_OPR, 0, OPR_RET);
        issue(OP_LIT, 0, 0);
        issue(OP_STO, 0, 1);

        n = 0;
        while (n < RAND_ITEMS) begin
            ins = random_instr();
            if (pc_after(ins) != 11'd0) begin
                issue(ins.opcode, int'(ins.level), int'(ins.operand));
                n++;
            end
        end
        issue(OP_JMP, 0, 0);
        repeat (4) begin
            ins = random_instr();
            issue(ins.opcode, int'(ins.level), int'(ins.operand));
        end

        while (instr_q.size() > 0 || step_q.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
